/* hw/rtl/smt_pkg.sv */
// Shared widths, types and helpers for the Sobel magnitude and threshold block.
package smt_pkg;

  localparam int unsigned PIX_W     = 8;   // grey pixel
  localparam int unsigned ROW_W     = 16;  // row counter and out_row
  localparam int unsigned OUT_COL_W = 11;  // out_col field
  localparam int unsigned FW_W      = 12;  // frame_width register
  localparam int unsigned FH_W      = 16;  // frame_height register
  localparam int unsigned THR_W     = 8;   // edge_threshold register
  localparam int unsigned MAG_W     = 8;   // magnitude and edge_res
  localparam int unsigned GRAD_W    = 12;  // signed gx / gy, -1020..1020
  localparam int unsigned SQ_W      = 21;  // gx*gx, at most 1040400
  localparam int unsigned SUM_W     = 22;  // gx*gx + gy*gy
  localparam int unsigned LINE_W    = 2 * PIX_W;  // two rows per line store word

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // register indexes on paddr[3:2]
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST    = 12'd640;
  localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST   = 16'd480;
  localparam logic [THR_W-1:0] EDGE_THRESHOLD_RST = 8'd30;

  localparam logic [MAG_W-1:0] EDGE_ON  = 8'hFF;
  localparam logic [MAG_W-1:0] EDGE_OFF = 8'h00;
  localparam logic [MAG_W-1:0] MAG_SAT  = 8'hFF;

  typedef logic [PIX_W-1:0] pix_t;

  // [row][col]; row 0 top, col 2 newest
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  // window rows and columns used as top/centre/bottom and left/centre/right
  typedef struct packed {
    logic [1:0] rt;
    logic [1:0] rm;
    logic [1:0] rb;
    logic [1:0] cl;
    logic [1:0] cm;
    logic [1:0] cr;
  } sel_t;

  function automatic pix_t win_pick(win_t win, logic [1:0] r, logic [1:0] c);
    pix_t v;
    v = '0;
    if (r != 2'd3 && c != 2'd3) v = win[r][c];
    return v;
  endfunction

  function automatic logic signed [GRAD_W-1:0] to_grad(pix_t p);
    return $signed({{(GRAD_W - PIX_W){1'b0}}, p});
  endfunction

endpackage

/* hw/rtl/smt_line_mem.sv */
// Two-row line store: one synchronous memory, one read and one write port.
module smt_line_mem
  import smt_pkg::*;
#(
  parameter int unsigned Depth = 2048,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output logic [LINE_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  logic [LINE_W-1:0] wr_data_i
);

  logic [LINE_W-1:0] mem [Depth];
  logic [LINE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/smt_grad.sv */
// Sobel gradient, sum of squares and 8-step floor square root on one shared unit.
module smt_grad
  import smt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  win_t             win_i,
  input  sel_t             sel_i,
  output logic             done_o,
  output logic [MAG_W-1:0] mag_o
);

  typedef enum logic [1:0] {
    G_IDLE,
    G_SQX,
    G_SUM,
    G_ROOT
  } gstate_e;

  gstate_e state_q;
  logic    done_q;

  logic signed [GRAD_W-1:0] gx_q, gy_q;
  logic [SQ_W-1:0]          sqx_q;
  logic [SUM_W-1:0]         sum_q;
  logic [MAG_W-1:0]         res_q;
  logic [MAG_W-1:0]         bit_q;

  logic signed [GRAD_W-1:0] p_tl, p_tm, p_tr, p_ml, p_mr, p_bl, p_bm, p_br;
  logic signed [GRAD_W-1:0] gx_d, gy_d;
  logic signed [GRAD_W-1:0] dx_m, dy_m;
  logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
  logic [MAG_W-1:0]         trial;
  logic [2*MAG_W-1:0]       trial_sq;
  logic                     sat;

  always_comb begin
    p_tl = to_grad(win_pick(win_i, sel_i.rt, sel_i.cl));
    p_tm = to_grad(win_pick(win_i, sel_i.rt, sel_i.cm));
    p_tr = to_grad(win_pick(win_i, sel_i.rt, sel_i.cr));
    p_ml = to_grad(win_pick(win_i, sel_i.rm, sel_i.cl));
    p_mr = to_grad(win_pick(win_i, sel_i.rm, sel_i.cr));
    p_bl = to_grad(win_pick(win_i, sel_i.rb, sel_i.cl));
    p_bm = to_grad(win_pick(win_i, sel_i.rb, sel_i.cm));
    p_br = to_grad(win_pick(win_i, sel_i.rb, sel_i.cr));
    dx_m = p_mr - p_ml;
    dy_m = p_tm - p_bm;
    gx_d = (p_tr - p_tl) + dx_m + dx_m + (p_br - p_bl);
    gy_d = (p_tl - p_bl) + dy_m + dy_m + (p_tr - p_br);
  end

  assign gx_sq    = gx_q * gx_q;
  assign gy_sq    = gy_q * gy_q;
  assign trial    = res_q | bit_q;
  assign trial_sq = trial * trial;
  // anything from 65536 up has a root of 256 or more
  assign sat      = (sum_q[SUM_W-1:2*MAG_W] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        G_IDLE: begin
          if (start_i) state_q <= G_SQX;
        end
        G_SQX: begin
          state_q <= G_SUM;
        end
        G_SUM: begin
          state_q <= G_ROOT;
        end
        G_ROOT: begin
          if (sat || bit_q[0]) begin
            state_q <= G_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= G_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      G_IDLE: begin
        if (start_i) begin
          gx_q <= gx_d;
          gy_q <= gy_d;
        end
      end
      G_SQX: begin
        sqx_q <= gx_sq[SQ_W-1:0];
      end
      G_SUM: begin
        sum_q <= SUM_W'(sqx_q) + SUM_W'(gy_sq[SQ_W-1:0]);
        res_q <= '0;
        bit_q <= {1'b1, {(MAG_W - 1){1'b0}}};
      end
      G_ROOT: begin
        if (sat) begin
          res_q <= MAG_SAT;
        end else if (trial_sq <= sum_q[2*MAG_W-1:0]) begin
          res_q <= trial;
        end
        bit_q <= bit_q >> 1;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign mag_o  = res_q;

endmodule

/* hw/rtl/sobel_magnitude_threshold.sv */
// Top level: stream control, pixel counters, 3x3 window, registers and result stage.
//
// Pixels enter on the s_axis channel in raster order, one 8-bit grey value per
// transaction. Results leave on m_axis: row, column, saturated gradient magnitude
// and the thresholded edge value of one frame position, with tlast on the final
// result caused by an input pixel. A pixel causes 0 to 4 results; they lag the
// input by one row and one column, and the last column and row are finished in
// the same run. frame_width, frame_height and edge_threshold sit on the APB port.
// One pixel is handled at a time: it is read from the line store into the window,
// and each result it causes then runs through the gradient, the two squaring
// multipliers and the 8-step square root, which ends early when the magnitude
// saturates.
// Reset clears the counters, the window and the result stage and restores the
// register defaults; the line store is not cleared and needs no clearing pass.
// When the receiver stalls, the finished result waits in the output register; the
// next pixel is still taken, and the block holds before loading the following
// result until that register is free.
module sobel_magnitude_threshold
  import smt_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // pixel stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] pixel
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [47:0]       m_axis_tdata,   // [15:0] out_row, [26:16] out_col,
                                            // [34:27] magnitude, [42:35] edge_res
  output logic              m_axis_tlast,   // last_of_run
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned WF_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CMP_W = (WF_W > FW_W) ? WF_W : FW_W;
  localparam int unsigned OUT_PAD = 48 - (ROW_W + OUT_COL_W + 2 * MAG_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_START,
    ST_CALC,
    ST_OUT
  } state_e;

  // configuration
  logic [FW_W-1:0]  frame_width_q;
  logic [FH_W-1:0]  frame_height_q;
  logic [THR_W-1:0] edge_threshold_q;
  logic             cfg_wr;

  // control
  state_e           state_q, state_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] r_q, r_d;
  logic [COL_W-1:0] c_q, c_d;
  logic             e1_q, e1_d;
  logic             lr_q, lr_d;
  logic             has_q, has_d;
  logic [3:0]       mask_q, mask_d;
  logic [1:0]       k_q, k_d;
  win_t             win_q, win_d;
  logic             m_valid_q, m_valid_d;

  // payload
  pix_t                 pix_q;
  logic [ROW_W-1:0]     o_row_q;
  logic [OUT_COL_W-1:0] o_col_q;
  logic [MAG_W-1:0]     o_mag_q;
  logic [MAG_W-1:0]     o_edge_q;
  logic                 o_last_q;

  // in-force geometry and item position
  logic [CMP_W-1:0] fw_ext;
  logic [WF_W-1:0]  wif;
  logic [FH_W-1:0]  hif;
  logic             wrap_pre;
  logic [COL_W-1:0] c0;
  logic [ROW_W:0]   r_pre;
  logic [ROW_W-1:0] r0;
  logic [WF_W-1:0]  c_next;
  logic [ROW_W:0]   r_next;

  logic             s_acc;
  logic             out_free;
  logic             load_out;
  logic [1:0]       k_sel;
  logic [3:0]       mask_rest;
  sel_t             sel;
  logic [1:0]       rt_n, cl_n;

  logic [LINE_W-1:0] rd_data;
  logic [LINE_W-1:0] wr_data;
  logic              grad_start;
  logic              grad_done;
  logic [MAG_W-1:0]  grad_mag;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q    <= FRAME_WIDTH_RST;
      frame_height_q   <= FRAME_HEIGHT_RST;
      edge_threshold_q <= EDGE_THRESHOLD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FRAME_WIDTH:    frame_width_q    <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT:   frame_height_q   <= pwdata[FH_W-1:0];
        REG_EDGE_THRESHOLD: edge_threshold_q <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FRAME_WIDTH:    prdata = APB_DW'(frame_width_q);
      REG_FRAME_HEIGHT:   prdata = APB_DW'(frame_height_q);
      REG_EDGE_THRESHOLD: prdata = APB_DW'(edge_threshold_q);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- geometry
  always_comb begin
    fw_ext = CMP_W'(frame_width_q);
    if (fw_ext < CMP_W'(2)) begin
      wif = WF_W'(2);
    end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
      wif = WF_W'(MAX_WIDTH);
    end else begin
      wif = WF_W'(fw_ext);
    end
    hif = (frame_height_q < FH_W'(2)) ? FH_W'(2) : frame_height_q;

    // geometry may have shrunk since the last pixel
    wrap_pre = (WF_W'(col_q) >= wif);
    c0       = wrap_pre ? '0 : col_q;
    r_pre    = wrap_pre ? ({1'b0, row_q} + (ROW_W + 1)'(1)) : {1'b0, row_q};
    r0       = (r_pre >= {1'b0, hif}) ? '0 : r_pre[ROW_W-1:0];
    c_next   = WF_W'(c0) + WF_W'(1);
    r_next   = {1'b0, r0} + (ROW_W + 1)'(1);
  end

  // ---------------------------------------------------------------- emission select
  always_comb begin
    if (mask_q[0])      k_sel = 2'd0;
    else if (mask_q[1]) k_sel = 2'd1;
    else if (mask_q[2]) k_sel = 2'd2;
    else                k_sel = 2'd3;

    // mirror without repeating the edge pixel
    rt_n = (r_q == ROW_W'(1)) ? 2'd2 : 2'd0;
    cl_n = (c_q == COL_W'(1)) ? 2'd2 : 2'd0;
    // k_sel[1]: bottom row of the frame, k_sel[0]: rightmost column
    sel.rt = k_sel[1] ? 2'd1 : rt_n;
    sel.rm = k_sel[1] ? 2'd2 : 2'd1;
    sel.rb = k_sel[1] ? 2'd1 : 2'd2;
    sel.cl = k_sel[0] ? 2'd1 : cl_n;
    sel.cm = k_sel[0] ? 2'd2 : 2'd1;
    sel.cr = k_sel[0] ? 2'd1 : 2'd2;
  end

  assign s_acc      = s_axis_tvalid & s_axis_tready;
  assign out_free   = ~m_valid_q | m_axis_tready;
  assign mask_rest  = mask_q & ~(4'b0001 << k_q);
  assign load_out   = (state_q == ST_OUT) & out_free;
  assign grad_start = (state_q == ST_START);
  assign wr_data    = {rd_data[PIX_W-1:0], pix_q};

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    r_d       = r_q;
    c_d       = c_q;
    e1_d      = e1_q;
    lr_d      = lr_q;
    has_d     = has_q;
    mask_d    = mask_q;
    k_d       = k_q;
    win_d     = win_q;
    m_valid_d = m_valid_q & ~m_axis_tready;

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          r_d   = r0;
          c_d   = c0;
          e1_d  = (WF_W'(c0) == wif - WF_W'(1));
          lr_d  = (r0 == hif - FH_W'(1));
          has_d = (r0 != '0) && (c0 != '0);
          if (c_next >= wif) begin
            col_d = '0;
            row_d = (r_next >= {1'b0, hif}) ? '0 : r_next[ROW_W-1:0];
          end else begin
            col_d = c_next[COL_W-1:0];
            row_d = r0;
          end
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          win_d[i][0] = win_q[i][1];
          win_d[i][1] = win_q[i][2];
        end
        win_d[0][2] = rd_data[LINE_W-1:PIX_W];
        win_d[1][2] = rd_data[PIX_W-1:0];
        win_d[2][2] = pix_q;
        mask_d  = has_q ? {e1_q & lr_q, lr_q, e1_q, 1'b1} : 4'b0000;
        state_d = has_q ? ST_START : ST_IDLE;
      end
      ST_START: begin
        k_d     = k_sel;
        state_d = ST_CALC;
      end
      ST_CALC: begin
        if (grad_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          mask_d    = mask_rest;
          state_d   = (mask_rest == 4'b0000) ? ST_IDLE : ST_START;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      row_q     <= '0;
      col_q     <= '0;
      r_q       <= '0;
      c_q       <= '0;
      e1_q      <= 1'b0;
      lr_q      <= 1'b0;
      has_q     <= 1'b0;
      mask_q    <= '0;
      k_q       <= '0;
      win_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      col_q     <= col_d;
      r_q       <= r_d;
      c_q       <= c_d;
      e1_q      <= e1_d;
      lr_q      <= lr_d;
      has_q     <= has_d;
      mask_q    <= mask_d;
      k_q       <= k_d;
      win_q     <= win_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      pix_q <= s_axis_tdata[PIX_W-1:0];
    end
    if (load_out) begin
      o_row_q  <= k_q[1] ? r_q : r_q - ROW_W'(1);
      o_col_q  <= OUT_COL_W'(k_q[0] ? c_q : c_q - COL_W'(1));
      o_mag_q  <= grad_mag;
      o_edge_q <= (grad_mag > edge_threshold_q) ? EDGE_ON : EDGE_OFF;
      o_last_q <= (mask_rest == 4'b0000);
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, o_edge_q, o_mag_q, o_col_q, o_row_q};
  assign m_axis_tlast  = o_last_q;

  // ---------------------------------------------------------------- units
  smt_line_mem #(
    .Depth (MAX_WIDTH)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (s_acc),
    .rd_addr_i (c0),
    .rd_data_o (rd_data),
    .wr_en_i   (state_q == ST_LOAD),
    .wr_addr_i (c_q),
    .wr_data_i (wr_data)
  );

  smt_grad u_grad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (grad_start),
    .win_i   (win_q),
    .sel_i   (sel),
    .done_o  (grad_done),
    .mag_o   (grad_mag)
  );

endmodule

/* dv/tb_sobel_magnitude_threshold.sv */
// Self-checking testbench for the streaming Sobel magnitude and threshold block.
`timescale 1ns / 100ps

module tb_sobel_magnitude_threshold;
  import smt_pkg::*;

  localparam int unsigned MAX_W          = 2048;
  localparam int unsigned RAND_ITEMS     = 410;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 40;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic [MAG_W-1:0]     mag;
    logic [MAG_W-1:0]     edge_res;
    logic                 last;
  } grad_res_t;

  // optional hand-typed magnitude for every result a pixel causes
  typedef struct packed {
    logic             fixed;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] edge_res;
  } pix_note_t;

  typedef enum logic {STEP_PIXEL, STEP_REG} step_kind_e;

  typedef struct {
    step_kind_e  kind;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    pix_t        pixel;
    pix_note_t   note;
  } dir_step_t;

  typedef enum logic [1:0] {TEX_NOISE, TEX_RAMP, TEX_STEP, TEX_FULL} texture_e;

  localparam pix_note_t NO_NOTE   = '{fixed: 1'b0, mag: '0, edge_res: '0};
  localparam pix_note_t FLAT_NOTE = '{fixed: 1'b1, mag: '0, edge_res: EDGE_OFF};

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata;   // [7:0] pixel
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [47:0]       m_axis_tdata;   // [15:0] out_row, [26:16] out_col,
                                     // [34:27] magnitude, [42:35] edge_res
  logic              m_axis_tlast;   // last_of_run
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sobel_magnitude_threshold #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // predictor state
  pix_t            line_mem [2*MAX_W];
  pix_t            win_q [9];       // [row*3 + col], row 0 top, col 2 newest
  int unsigned     row_cnt;
  int unsigned     col_cnt;
  logic [FW_W-1:0]  cfg_width;
  logic [FH_W-1:0]  cfg_height;
  logic [THR_W-1:0] cfg_thr;

  grad_res_t   expected_q [$];
  pix_note_t   note_q [$];
  int unsigned err_cnt;
  int unsigned burst_left;
  int unsigned rand_items;
  dir_step_t   dir_steps [$];

  logic [15:0] ready_pat;
  int unsigned pat_pos;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report(string what, int unsigned got, int unsigned want);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic grad_res_t grad_at(int r, int c, int rt, int rm, int rb,
                                        int cl, int cm, int cr);
    int        gx;
    int        gy;
    int        ssq;
    int        trial;
    int        b;
    grad_res_t res;
    logic [MAG_W-1:0] root;
    gx = (int'(win_q[rt*3+cr]) - int'(win_q[rt*3+cl]))
       + 2 * (int'(win_q[rm*3+cr]) - int'(win_q[rm*3+cl]))
       + (int'(win_q[rb*3+cr]) - int'(win_q[rb*3+cl]));
    gy = (int'(win_q[rt*3+cl]) - int'(win_q[rb*3+cl]))
       + 2 * (int'(win_q[rt*3+cm]) - int'(win_q[rb*3+cm]))
       + (int'(win_q[rt*3+cr]) - int'(win_q[rb*3+cr]));
    ssq = gx * gx + gy * gy;
    if (ssq >= 65536) begin
      root = MAG_SAT;
    end else begin
      root = '0;
      for (b = 7; b >= 0; b--) begin
        trial = int'(root) | (1 << b);
        if (trial * trial <= ssq) root = MAG_W'(trial);
      end
    end
    res.row      = ROW_W'(r);
    res.col      = OUT_COL_W'(c);
    res.mag      = root;
    res.edge_res = (root > cfg_thr) ? EDGE_ON : EDGE_OFF;
    res.last     = 1'b0;
    return res;
  endfunction

  task automatic sobel_predict(pix_t p, pix_note_t note);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int          rt;
    int          cl;
    int          i;
    pix_t        top;
    pix_t        mid;
    grad_res_t   run_q [$];
    w = (cfg_width < 2) ? 2 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
    h = (cfg_height < 2) ? 2 : cfg_height;
    // geometry may have shrunk under the counters
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    r = row_cnt;
    c = col_cnt;

    top = line_mem[MAX_W + c];
    mid = line_mem[c];
    line_mem[MAX_W + c] = mid;
    line_mem[c] = p;
    for (i = 0; i < 3; i++) begin
      win_q[i*3]   = win_q[i*3+1];
      win_q[i*3+1] = win_q[i*3+2];
    end
    win_q[2] = top;
    win_q[5] = mid;
    win_q[8] = p;

    if (r >= 1 && c >= 1) begin
      // mirror without repeating the edge: index -1 reads index 1
      rt = (r == 1) ? 2 : 0;
      cl = (c == 1) ? 2 : 0;
      run_q.push_back(grad_at(r - 1, c - 1, rt, 1, 2, cl, 1, 2));
      if (c == w - 1) run_q.push_back(grad_at(r - 1, c, rt, 1, 2, 1, 2, 1));
      if (r == h - 1) begin
        run_q.push_back(grad_at(r, c - 1, 1, 2, 1, cl, 1, 2));
        if (c == w - 1) run_q.push_back(grad_at(r, c, 1, 2, 1, 1, 2, 1));
      end
      run_q[run_q.size() - 1].last = 1'b1;
      foreach (run_q[k]) begin
        if (note.fixed) begin
          run_q[k].mag      = note.mag;
          run_q[k].edge_res = note.edge_res;
        end
        expected_q.push_back(run_q[k]);
      end
    end

    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= h) row_cnt = 0;
    end
  endtask

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    grad_res_t got;
    grad_res_t want;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FRAME_WIDTH:    cfg_width  = pwdata[FW_W-1:0];
          REG_FRAME_HEIGHT:   cfg_height = pwdata[FH_W-1:0];
          REG_EDGE_THRESHOLD: cfg_thr    = pwdata[THR_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sobel_predict(s_axis_tdata, note_q.pop_front());
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.row      = m_axis_tdata[15:0];
        got.col      = m_axis_tdata[26:16];
        got.mag      = m_axis_tdata[34:27];
        got.edge_res = m_axis_tdata[42:35];
        got.last     = m_axis_tlast;
        if (expected_q.size() == 0) begin
          report("result with nothing pending, out_row", got.row, 0);
        end else begin
          want = expected_q.pop_front();
          if (got.row !== want.row) report("out_row", got.row, want.row);
          if (got.col !== want.col) report("out_col", got.col, want.col);
          if (got.mag !== want.mag) report("magnitude", got.mag, want.mag);
          if (got.edge_res !== want.edge_res) report("edge_res", got.edge_res, want.edge_res);
          if (got.last !== want.last) report("tlast", got.last, want.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(negedge clk_i) begin
    if (pat_pos == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pat = 16'hFFFF;
        1:       ready_pat = ~(16'h0001 << $urandom_range(0, 15));
        2:       ready_pat = 16'($urandom);
        default: ready_pat = 16'hFFFF >> $urandom_range(4, 15);  // long stall at the tail
      endcase
    end
    m_axis_tready <= ready_pat[pat_pos];
    pat_pos = (pat_pos + 1) % 16;
  end

  // ---------------------------------------------------------------- watchdog

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- drivers

  task automatic apb_xfer(logic wr, logic [1:0] idx, logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [31:0] value);
    logic [31:0] rd;
    logic [31:0] want;
    apb_xfer(1'b1, idx, value, rd);
    apb_xfer(1'b0, idx, '0, rd);
    case (idx)
      REG_FRAME_WIDTH:  want = {20'd0, value[FW_W-1:0]};
      REG_FRAME_HEIGHT: want = {16'd0, value[FH_W-1:0]};
      default:          want = {24'd0, value[THR_W-1:0]};
    endcase
    if (rd !== want) report("register readback", rd, want);
  endtask

  // called and returns at a falling edge
  task automatic send_pixel(pix_t p, pix_note_t note);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 20);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    note_q.push_back(note);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // block must be idle before a register write
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic pix_t next_pixel(texture_e tex, int k, int base, int amp);
    int v;
    case (tex)
      TEX_NOISE: v = base + $urandom_range(0, amp);
      TEX_RAMP:  v = (k * amp + $urandom_range(0, 3)) % 256;
      TEX_STEP:  v = ((k % 5) < 2) ? base : base + amp * 4;
      default:   v = $urandom_range(0, 255);
    endcase
    return pix_t'((v > 255) ? 255 : v);
  endfunction

  task automatic add_reg(logic [1:0] idx, logic [31:0] value);
    dir_step_t s;
    s = '{kind: STEP_REG, reg_idx: idx, value: value, pixel: '0, note: NO_NOTE};
    dir_steps.push_back(s);
  endtask

  task automatic add_pix(pix_t p, pix_note_t note);
    dir_step_t s;
    s = '{kind: STEP_PIXEL, reg_idx: '0, value: '0, pixel: p, note: note};
    dir_steps.push_back(s);
  endtask

  // ---------------------------------------------------------------- stimulus

  initial begin
    logic [31:0] rd;
    logic [31:0] wv;
    logic [31:0] hv;
    int unsigned weff;
    int unsigned heff;
    int unsigned n;
    int          base;
    int          amp;
    texture_e    tex;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    err_cnt       = 0;
    burst_left    = 0;
    rand_items    = 0;
    pat_pos       = 0;
    ready_pat     = 16'hFFFF;
    row_cnt       = 0;
    col_cnt       = 0;
    cfg_width     = FRAME_WIDTH_RST;
    cfg_height    = FRAME_HEIGHT_RST;
    cfg_thr       = EDGE_THRESHOLD_RST;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win_q[i]) win_q[i] = '0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    apb_xfer(1'b0, REG_FRAME_WIDTH, '0, rd);
    if (rd !== 32'(FRAME_WIDTH_RST)) report("frame_width after reset", rd, FRAME_WIDTH_RST);
    apb_xfer(1'b0, REG_FRAME_HEIGHT, '0, rd);
    if (rd !== 32'(FRAME_HEIGHT_RST)) report("frame_height after reset", rd, FRAME_HEIGHT_RST);
    apb_xfer(1'b0, REG_EDGE_THRESHOLD, '0, rd);
    if (rd !== 32'(EDGE_THRESHOLD_RST)) begin
      report("edge_threshold after reset", rd, EDGE_THRESHOLD_RST);
    end

    // 2x2 frames: both mirrors fold onto the same pixel, so every gradient is zero
    add_reg(REG_FRAME_WIDTH, 32'd2);
    add_reg(REG_FRAME_HEIGHT, 32'd2);
    add_reg(REG_EDGE_THRESHOLD, 32'd0);
    add_pix(8'h00, FLAT_NOTE);
    add_pix(8'hFF, FLAT_NOTE);
    add_pix(8'hFF, FLAT_NOTE);
    add_pix(8'h00, FLAT_NOTE);
    // undersized geometry is treated as 2x2
    add_reg(REG_FRAME_WIDTH, 32'd1);
    add_reg(REG_FRAME_HEIGHT, 32'd0);
    add_pix(8'hA5, FLAT_NOTE);
    add_pix(8'h5A, FLAT_NOTE);
    add_pix(8'h00, FLAT_NOTE);
    add_pix(8'hFF, FLAT_NOTE);
    // 3x3 with a bright right column and bright bottom row around a dark corner, against near-max threshold
    add_reg(REG_FRAME_WIDTH, 32'd3);
    add_reg(REG_FRAME_HEIGHT, 32'd3);
    add_reg(REG_EDGE_THRESHOLD, 32'd254);
    add_pix(8'h00, NO_NOTE);
    add_pix(8'h00, NO_NOTE);
    add_pix(8'hFF, NO_NOTE);
    add_pix(8'h00, NO_NOTE);
    add_pix(8'h00, NO_NOTE);
    add_pix(8'hFF, NO_NOTE);
    add_pix(8'hFF, NO_NOTE);
    add_pix(8'hFF, NO_NOTE);
    add_pix(8'h00, NO_NOTE);

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == STEP_REG) begin
        drain_results();
        set_reg(dir_steps[i].reg_idx, dir_steps[i].value);
      end else begin
        send_pixel(dir_steps[i].pixel, dir_steps[i].note);
      end
    end
    drain_results();

    // full-width frame: reaches the last column and fills every line store entry
    set_reg(REG_FRAME_WIDTH, 32'd2048);
    set_reg(REG_FRAME_HEIGHT, 32'd2);
    set_reg(REG_EDGE_THRESHOLD, $urandom_range(0, 60));
    base = $urandom_range(0, 200);
    for (int k = 0; k < 2 * 2048; k++) send_pixel(next_pixel(TEX_NOISE, k, base, 15), NO_NOTE);
    drain_results();

    // oversized width clamps to the maximum; stop part way through the first row
    set_reg(REG_FRAME_WIDTH, 32'hFFFF_FFFF);
    for (int k = 0; k < 20; k++) send_pixel(next_pixel(TEX_FULL, k, 0, 0), NO_NOTE);
    drain_results();

    // narrow mid-row: column counter is past the new width, so a fresh row starts
    set_reg(REG_FRAME_WIDTH, 32'd5);
    set_reg(REG_FRAME_HEIGHT, 32'h0000_FFFF);
    set_reg(REG_EDGE_THRESHOLD, 32'd255);
    for (int k = 0; k < 30; k++) send_pixel(next_pixel(TEX_STEP, k, 20, 40), NO_NOTE);
    drain_results();

    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(0, 11))
        0:       wv = $urandom_range(0, 1);
        1:       wv = $urandom_range(13, 48);
        2:       wv = ($urandom_range(0, 1) != 0) ? 32'd2049 : 32'd4095;
        default: wv = $urandom_range(2, 10);
      endcase
      case ($urandom_range(0, 9))
        0:       hv = $urandom_range(0, 1);
        1:       hv = 32'd65535;
        2:       hv = $urandom_range(9, 20);
        default: hv = $urandom_range(2, 6);
      endcase
      // random upper bits check that the register ignores them
      set_reg(REG_FRAME_WIDTH, {$urandom_range(0, 1) != 0 ? 20'($urandom) : 20'd0, wv[11:0]});
      set_reg(REG_FRAME_HEIGHT, hv);
      case ($urandom_range(0, 5))
        0:       set_reg(REG_EDGE_THRESHOLD, 32'd0);
        1:       set_reg(REG_EDGE_THRESHOLD, 32'd255);
        default: set_reg(REG_EDGE_THRESHOLD, $urandom_range(0, 150));
      endcase

      weff = (wv[11:0] < 2) ? 2 : ((wv[11:0] > MAX_W) ? MAX_W : wv[11:0]);
      heff = (hv < 2) ? 2 : hv;
      if (weff * heff <= 75 && $urandom_range(0, 3) != 0) begin
        n = weff * heff * $urandom_range(1, 2);
      end else begin
        n = $urandom_range(3, 60);
      end
      tex  = texture_e'($urandom_range(0, 3));
      base = $urandom_range(0, 200);
      amp  = $urandom_range(1, 31);
      for (int k = 0; k < n; k++) begin
        send_pixel(next_pixel(tex, k, base, amp), NO_NOTE);
        rand_items++;
      end
      drain_results();
    end

    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/smt_pkg.sv
hw/rtl/smt_line_mem.sv
hw/rtl/smt_grad.sv
hw/rtl/sobel_magnitude_threshold.sv
dv/tb_sobel_magnitude_threshold.sv
